@@ hdl/smtp_command_argument_parser_core_macros.svh @@
// Assertion macros used by the SMTP argument parser core
`ifndef SMTP_COMMAND_ARGUMENT_PARSER_CORE_MACROS_SVH
`define SMTP_COMMAND_ARGUMENT_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SMTPAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smtpap: same-cycle check failed");

// next-cycle implication
`define SMTPAP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smtpap: next-cycle check failed");

`endif

@@ hdl/smtpap_pkg.sv @@
// Types, codes and constants for the SMTP argument parser
package smtpap_pkg;

  localparam int FLEN_W = 9;
  localparam int KPOS_W = 3;

  localparam logic [1:0] OP_HELO = 2'd0;
  localparam logic [1:0] OP_MAIL = 2'd1;
  localparam logic [1:0] OP_RCPT = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CASE_MSK = 8'hDF;

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0_0000_0000_0001,
    PH_SPACE     = 13'b0_0000_0000_0010,
    PH_KEYWORD   = 13'b0_0000_0000_0100,
    PH_COLON     = 13'b0_0000_0000_1000,
    PH_LT        = 13'b0_0000_0001_0000,
    PH_LOC_FIRST = 13'b0_0000_0010_0000,
    PH_LOC       = 13'b0_0000_0100_0000,
    PH_DOM_FIRST = 13'b0_0000_1000_0000,
    PH_DOM_PLAIN = 13'b0_0001_0000_0000,
    PH_DOM_LIT   = 13'b0_0010_0000_0000,
    PH_DOM_END   = 13'b0_0100_0000_0000,
    PH_CR        = 13'b0_1000_0000_0000,
    PH_LF        = 13'b1_0000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CAP_NONE   = 2'd0,
    CAP_LOCAL  = 2'd1,
    CAP_DOMAIN = 2'd2
  } cap_t;

  typedef struct packed {
    logic local_ok;
    logic literal_ok;
    logic domain_ok;
  } class_t;

  typedef struct packed {
    phase_t              phase;
    logic [FLEN_W-1:0]   flen;
    logic [KPOS_W-1:0]   kpos;
    logic [1:0]          kind;
  } pstate_t;

  typedef struct packed {
    logic [7:0] captured_char;
    cap_t       capture_kind;
    status_t    status;
  } result_t;

  // expected keyword letter, upper case
  function automatic logic [7:0] kw_char(input logic [1:0] kind,
                                         input logic [KPOS_W-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == OP_MAIL) begin
      unique case (pos)
        3'd0:    ch = 8'h46;
        3'd1:    ch = 8'h52;
        3'd2:    ch = 8'h4F;
        3'd3:    ch = 8'h4D;
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (pos)
        3'd0:    ch = 8'h54;
        3'd1:    ch = 8'h4F;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [KPOS_W-1:0] kw_len(input logic [1:0] kind);
    return (kind == OP_MAIL) ? KPOS_W'(4) : KPOS_W'(2);
  endfunction

endpackage

@@ hdl/smtpap_class.sv @@
// Character class decode for local part, literal and plain domain bytes
module smtpap_class
  import smtpap_pkg::*;
(
  input  logic [7:0] ch,
  output class_t     cls
);

  always_comb begin
    cls.local_ok = (ch == 8'd33) ||
                   (ch > 8'd34 && ch < 8'd40) ||
                   (ch == 8'd42) || (ch == 8'd43) ||
                   (ch > 8'd44 && ch < 8'd58) ||
                   (ch == 8'd61) ||
                   (ch > 8'd64 && ch < 8'd91) ||
                   (ch > 8'd93 && ch < 8'd127);
    cls.literal_ok = (ch > 8'd32 && ch < 8'd91) ||
                     (ch > 8'd93 && ch < 8'd127);
    cls.domain_ok = (ch == 8'd45) || (ch == 8'd46) ||
                    (ch > 8'd64 && ch < 8'd91) ||
                    (ch > 8'd96 && ch < 8'd123);
  end

endmodule

@@ hdl/smtpap_fsm.sv @@
// Next-state and result logic of the parser for one byte
module smtpap_fsm
  import smtpap_pkg::*;
#(
  parameter int LOCAL_MAX  = 64,
  parameter int DOMAIN_MAX = 256
)
(
  input  pstate_t    cur,
  input  logic [1:0] op,
  input  logic [7:0] ch,
  input  logic       start,
  output pstate_t    nxt,
  output result_t    res
);

  localparam logic [FLEN_W-1:0] LOC_LIM = FLEN_W'(LOCAL_MAX);
  localparam logic [FLEN_W-1:0] DOM_LIM = FLEN_W'(DOMAIN_MAX);
  localparam logic [FLEN_W-1:0] LIT_LIM = FLEN_W'(DOMAIN_MAX - 1);

  class_t            cls;
  pstate_t           eff;
  status_t           st;
  cap_t              cap;
  logic [FLEN_W-1:0] flen_inc;
  logic [KPOS_W-1:0] kpos_inc;

  smtpap_class u_class (
    .ch  (ch),
    .cls (cls)
  );

  always_comb begin
    eff = cur;
    if (start) begin
      eff.kind  = op;
      eff.flen  = '0;
      eff.kpos  = '0;
      eff.phase = (op == OP_NONE) ? PH_IDLE : PH_SPACE;
    end
  end

  assign flen_inc = eff.flen + FLEN_W'(1);
  assign kpos_inc = eff.kpos + KPOS_W'(1);

  always_comb begin
    nxt = eff;
    st  = (start && op == OP_NONE) ? ST_BAD : ST_BUSY;
    cap = CAP_NONE;
    unique case (eff.phase)
      PH_SPACE: begin
        if (ch == CH_SP) nxt.phase = (eff.kind == OP_HELO) ? PH_DOM_FIRST : PH_KEYWORD;
        else st = ST_BAD;
      end
      PH_KEYWORD: begin
        if ((ch & CASE_MSK) == kw_char(eff.kind, eff.kpos)) begin
          nxt.kpos = kpos_inc;
          if (kpos_inc >= kw_len(eff.kind)) nxt.phase = PH_COLON;
        end else begin
          st = ST_BAD;
        end
      end
      PH_COLON: begin
        if (ch == CH_COLON) nxt.phase = PH_LT;
        else st = ST_BAD;
      end
      PH_LT: begin
        if (ch == CH_LT) begin
          nxt.phase = PH_LOC_FIRST;
          nxt.flen  = '0;
        end else begin
          st = ST_BAD;
        end
      end
      PH_LOC_FIRST, PH_LOC: begin
        if (cls.local_ok) begin
          if (eff.flen >= LOC_LIM) st = ST_BAD;
          else begin
            nxt.flen  = flen_inc;
            cap       = CAP_LOCAL;
            nxt.phase = PH_LOC;
          end
        end else if (eff.phase == PH_LOC && ch == CH_AT) begin
          nxt.phase = PH_DOM_FIRST;
          nxt.flen  = '0;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_FIRST: begin
        nxt.flen = '0;
        if (ch == CH_LBR) begin
          nxt.flen  = FLEN_W'(1);
          cap       = CAP_DOMAIN;
          nxt.phase = PH_DOM_LIT;
        end else if (cls.domain_ok) begin
          nxt.flen  = FLEN_W'(1);
          cap       = CAP_DOMAIN;
          nxt.phase = PH_DOM_PLAIN;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_PLAIN, PH_DOM_END: begin
        if (eff.phase == PH_DOM_PLAIN && cls.domain_ok) begin
          if (eff.flen >= DOM_LIM) st = ST_BAD;
          else begin
            nxt.flen = flen_inc;
            cap      = CAP_DOMAIN;
          end
        end else if (eff.kind == OP_HELO && ch == CH_CR) begin
          nxt.phase = PH_LF;
        end else if (eff.kind != OP_HELO && ch == CH_GT) begin
          nxt.phase = PH_CR;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_LIT: begin
        if (cls.literal_ok) begin
          if (eff.flen >= LIT_LIM) st = ST_BAD;
          else begin
            nxt.flen = flen_inc;
            cap      = CAP_DOMAIN;
          end
        end else if (ch == CH_RBR) begin
          nxt.flen  = flen_inc;
          cap       = CAP_DOMAIN;
          nxt.phase = PH_DOM_END;
        end else begin
          st = ST_BAD;
        end
      end
      PH_CR: begin
        if (ch == CH_CR) nxt.phase = PH_LF;
        else st = ST_BAD;
      end
      PH_LF: begin
        if (ch == CH_LF) begin
          st        = ST_OK;
          nxt.phase = PH_IDLE;
        end else begin
          st = ST_BAD;
        end
      end
      default: ;
    endcase
    if (st == ST_BAD) begin
      nxt.phase = PH_IDLE;
      cap       = CAP_NONE;
    end
  end

  always_comb begin
    res.captured_char = (cap != CAP_NONE) ? ch : 8'h00;
    res.capture_kind  = cap;
    res.status        = st;
  end

endmodule

@@ hdl/smtp_command_argument_parser_core.sv @@
// Top level of the SMTP command argument parser: input stage, parser state, result stage
// Datapath: a taken byte is held in the input register, then its result is registered for out_*.
// Throughput: one byte per cycle while out_tready is high; set by the single
//   input-register to result-register pass that also updates the parser state.
// Reset (rst_n low, synchronous): both stages empty, parser idle with zero
//   length, keyword position and command kind.
module smtp_command_argument_parser_core
  import smtpap_pkg::*;
#(
  parameter int LOCAL_MAX  = 64,
  parameter int DOMAIN_MAX = 256
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [2:0] in_tuser,   // [1:0] operation, [2] line_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] captured_char
  output logic [3:0] out_tuser   // [1:0] capture_kind, [3:2] status
);

`include "smtp_command_argument_parser_core_macros.svh"

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic [1:0] in_op_r;
  logic       in_start_r;
  pstate_t    pst_r;
  pstate_t    pst_nxt;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  smtpap_fsm #(
    .LOCAL_MAX  (LOCAL_MAX),
    .DOMAIN_MAX (DOMAIN_MAX)
  ) u_fsm (
    .cur   (pst_r),
    .op    (in_op_r),
    .ch    (in_byte_r),
    .start (in_start_r),
    .nxt   (pst_nxt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_op_r    <= in_tuser[1:0];
      in_start_r <= in_tuser[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r.phase <= PH_IDLE;
      pst_r.flen  <= '0;
      pst_r.kpos  <= '0;
      pst_r.kind  <= OP_HELO;
    end else if (advance) begin
      pst_r <= pst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_res_r.captured_char;
  assign out_tuser[1:0] = out_res_r.capture_kind;
  assign out_tuser[3:2] = out_res_r.status;

  `SMTPAP_ASSERT_NXT(a_bad_goes_idle, advance && res.status == ST_BAD, pst_r.phase == PH_IDLE)
  `SMTPAP_ASSERT_NXT(a_ok_goes_idle, advance && res.status == ST_OK, pst_r.phase == PH_IDLE)
  `SMTPAP_ASSERT_IMP(a_capture_busy, out_valid_r && out_res_r.capture_kind != CAP_NONE, out_res_r.status == ST_BUSY)
  `SMTPAP_ASSERT_IMP(a_no_capture_zero, out_valid_r && out_res_r.capture_kind == CAP_NONE, out_res_r.captured_char == 8'h00)
  `SMTPAP_ASSERT_NXT(a_stall_holds, out_valid_r && !out_tready, out_valid_r && $stable(out_res_r))

endmodule

@@ tb/sv/smtp_command_argument_parser_core_tb.sv @@
// Self-checking testbench for the SMTP command argument parser core
`timescale 1ns / 100ps

module smtp_command_argument_parser_core_tb;
  import smtpap_pkg::*;

  localparam int LOCAL_MAX   = 64;
  localparam int DOMAIN_MAX  = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 150;

  typedef struct {
    logic [1:0] op;
    logic [7:0] ch;
    logic       start;
  } byte_item_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] ch;
    logic       start;
    bit         fixed;
    logic [7:0] x_char;
    cap_t       x_kind;
    status_t    x_stat;
  } row_t;

  typedef enum int {RX_FREE, RX_COIN, RX_BEAT} rx_mode_t;
  typedef enum int {DMG_NONE, DMG_BYTE, DMG_CUT, DMG_BADOP} damage_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic [2:0] in_tuser = 3'b000;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;

  smtp_command_argument_parser_core #(
    .LOCAL_MAX (LOCAL_MAX),
    .DOMAIN_MAX(DOMAIN_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // parser state as predicted
  phase_t     ps_phase = PH_IDLE;
  int         ps_len = 0;
  int         ps_kpos = 0;
  logic [1:0] ps_cmd = OP_HELO;

  logic [7:0] from_word [4] = '{"F", "R", "O", "M"};
  logic [7:0] to_word [2] = '{"T", "O"};
  logic [7:0] nasty_bytes [8] = '{8'h22, 8'h00, 8'hFF, 8'h80, CH_AT, CH_SP, CH_LBR, 8'h5C};

  result_t    due_results[$];
  byte_item_t line_q[$];
  int         miss_count = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  bit         hold_req = 1'b0;

  row_t opening_rows [25] = '{
    '{OP_HELO, 8'hFF,    1'b0, 1'b1, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_NONE, CH_SP,    1'b1, 1'b1, 8'h00, CAP_NONE, ST_BAD},
    '{OP_RCPT, "X",      1'b1, 1'b1, 8'h00, CAP_NONE, ST_BAD},
    '{OP_HELO, CH_SP,    1'b1, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_NONE, "a",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_HELO, CH_CR,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_HELO, CH_LF,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_SP,    1'b1, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, "f",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_RCPT, "R",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, "o",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, "M",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_COLON, 1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_LT,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, "~",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_AT,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_LBR,   1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, "!",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_RBR,   1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_GT,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_CR,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_MAIL, CH_LF,    1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_RCPT, CH_SP,    1'b1, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_RCPT, "t",      1'b0, 1'b0, 8'h00, CAP_NONE, ST_BUSY},
    '{OP_RCPT, 8'h80,    1'b0, 1'b1, 8'h00, CAP_NONE, ST_BAD}
  };

  function automatic bit is_local(input logic [7:0] c);
    return c == 8'd33 || (c >= 8'd35 && c <= 8'd39) || c == 8'd42 || c == 8'd43 ||
           (c >= 8'd45 && c <= 8'd57) || c == 8'd61 ||
           (c >= 8'd65 && c <= 8'd90) || (c >= 8'd94 && c <= 8'd126);
  endfunction

  function automatic bit is_literal(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd90) || (c >= 8'd94 && c <= 8'd126);
  endfunction

  function automatic bit is_plain(input logic [7:0] c);
    return c == 8'd45 || c == 8'd46 || (c >= 8'd65 && c <= 8'd90) ||
           (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic status_t end_of_domain(input logic [7:0] c);
    if (ps_cmd == OP_HELO) begin
      if (c == CH_CR) begin
        ps_phase = PH_LF;
        return ST_BUSY;
      end
    end else if (c == CH_GT) begin
      ps_phase = PH_CR;
      return ST_BUSY;
    end
    return ST_BAD;
  endfunction

  function automatic result_t parse_byte(input logic [1:0] op, input logic [7:0] c,
                                         input logic start);
    status_t    st;
    cap_t       cap;
    result_t    res;
    int         wlen;
    logic [7:0] want;
    st  = ST_BUSY;
    cap = CAP_NONE;
    if (start) begin
      ps_cmd  = op;
      ps_len  = 0;
      ps_kpos = 0;
      if (op == OP_NONE) begin
        ps_phase = PH_IDLE;
        st = ST_BAD;
      end else begin
        ps_phase = PH_SPACE;
      end
    end
    case (ps_phase)
      PH_SPACE: begin
        if (c == CH_SP) ps_phase = (ps_cmd == OP_HELO) ? PH_DOM_FIRST : PH_KEYWORD;
        else st = ST_BAD;
      end
      PH_KEYWORD: begin
        wlen = (ps_cmd == OP_MAIL) ? 4 : 2;
        want = 8'h00;
        if (ps_kpos < wlen) begin
          if (ps_cmd == OP_MAIL) want = from_word[ps_kpos];
          else want = to_word[ps_kpos];
        end
        if (ps_kpos < wlen && (c & CASE_MSK) == want) begin
          ps_kpos++;
          if (ps_kpos >= wlen) ps_phase = PH_COLON;
        end else begin
          st = ST_BAD;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON) ps_phase = PH_LT;
        else st = ST_BAD;
      end
      PH_LT: begin
        if (c == CH_LT) begin
          ps_phase = PH_LOC_FIRST;
          ps_len = 0;
        end else begin
          st = ST_BAD;
        end
      end
      PH_LOC_FIRST, PH_LOC: begin
        if (is_local(c)) begin
          if (ps_len >= LOCAL_MAX) begin
            st = ST_BAD;
          end else begin
            ps_len++;
            cap = CAP_LOCAL;
            ps_phase = PH_LOC;
          end
        end else if (ps_phase == PH_LOC && c == CH_AT) begin
          ps_phase = PH_DOM_FIRST;
          ps_len = 0;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_FIRST: begin
        ps_len = 0;
        if (c == CH_LBR) begin
          ps_len = 1;
          cap = CAP_DOMAIN;
          ps_phase = PH_DOM_LIT;
        end else if (is_plain(c)) begin
          ps_len = 1;
          cap = CAP_DOMAIN;
          ps_phase = PH_DOM_PLAIN;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_PLAIN: begin
        if (is_plain(c)) begin
          if (ps_len >= DOMAIN_MAX) begin
            st = ST_BAD;
          end else begin
            ps_len++;
            cap = CAP_DOMAIN;
          end
        end else begin
          st = end_of_domain(c);
        end
      end
      PH_DOM_LIT: begin
        if (is_literal(c)) begin
          if (ps_len >= DOMAIN_MAX - 1) begin
            st = ST_BAD;
          end else begin
            ps_len++;
            cap = CAP_DOMAIN;
          end
        end else if (c == CH_RBR) begin
          ps_len++;
          cap = CAP_DOMAIN;
          ps_phase = PH_DOM_END;
        end else begin
          st = ST_BAD;
        end
      end
      PH_DOM_END: st = end_of_domain(c);
      PH_CR: begin
        if (c == CH_CR) ps_phase = PH_LF;
        else st = ST_BAD;
      end
      PH_LF: begin
        if (c == CH_LF) begin
          st = ST_OK;
          ps_phase = PH_IDLE;
        end else begin
          st = ST_BAD;
        end
      end
      default: ;
    endcase
    if (st == ST_BAD) begin
      ps_phase = PH_IDLE;
      cap = CAP_NONE;
    end
    res.captured_char = (cap != CAP_NONE) ? c : 8'h00;
    res.capture_kind  = cap;
    res.status        = st;
    return res;
  endfunction

  // one transfer on the input side; called and returning at a falling edge
  task automatic send_byte(input logic [1:0] op, input logic [7:0] c, input logic start,
                           input bit fixed, input result_t fixed_res);
    result_t res;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= {start, op};
    do @(posedge clk); while (!in_tready);
    res = parse_byte(op, c, start);
    due_results.push_back(fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_local();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_local(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_literal();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_literal(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(45, 122)); while (!is_plain(c));
    return c;
  endfunction

  // operation is don't-care away from the line start, so it is randomised there
  function automatic void add_byte(input logic [7:0] c);
    line_q.push_back('{2'($urandom_range(0, 3)), c, 1'b0});
  endfunction

  task automatic run_line(input logic [1:0] op, input int loc_len, input int dom_len,
                          input bit lit, input bit may_damage);
    damage_t dmg;
    int      pick;
    int      pos;
    result_t none;
    line_q.delete();
    none = '{8'h00, CAP_NONE, ST_BUSY};
    line_q.push_back('{op, CH_SP, 1'b1});
    if (op != OP_HELO) begin
      if (op == OP_MAIL) foreach (from_word[i]) add_byte(from_word[i] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      else foreach (to_word[i]) add_byte(to_word[i] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      add_byte(CH_COLON);
      add_byte(CH_LT);
      repeat (loc_len) add_byte(pick_local());
      add_byte(CH_AT);
    end
    if (lit) begin
      add_byte(CH_LBR);
      repeat (dom_len) add_byte(pick_literal());
      add_byte(CH_RBR);
    end else begin
      repeat (dom_len) add_byte(pick_plain());
    end
    if (op != OP_HELO) add_byte(CH_GT);
    add_byte(CH_CR);
    add_byte(CH_LF);

    dmg = DMG_NONE;
    if (may_damage) begin
      pick = $urandom_range(0, 9);
      if (pick == 6 || pick == 7) dmg = DMG_BYTE;
      else if (pick == 8) dmg = DMG_CUT;
      else if (pick == 9) dmg = DMG_BADOP;
    end
    case (dmg)
      DMG_BYTE: begin
        pos = $urandom_range(0, line_q.size() - 1);
        if ($urandom_range(0, 1)) line_q[pos].ch = nasty_bytes[$urandom_range(0, 7)];
        else line_q[pos].ch = 8'($urandom_range(0, 255));
      end
      DMG_CUT:   repeat ($urandom_range(1, line_q.size() - 1)) void'(line_q.pop_back());
      DMG_BADOP: line_q[0].op = OP_NONE;
      default: ;
    endcase

    foreach (line_q[i]) begin
      send_byte(line_q[i].op, line_q[i].ch, line_q[i].start, 1'b0, none);
      bytes_sent++;
    end
    // stray bytes between lines
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4))
        send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, none);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    static rx_mode_t rx_mode = RX_FREE;
    static int       mode_left = 0;
    static int       hold_left = 0;
    static int       tick = 0;
    logic            rdy;
    tick++;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_COIN: rdy = 1'($urandom_range(0, 1));
        RX_BEAT: rdy = (tick % 5) < 3;
        default: rdy = 1'b1;
      endcase
    end
    out_tready <= rdy;
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("unexpected result: char %02h kind %0d status %0d",
                   out_tdata, out_tuser[1:0], out_tuser[3:2]);
      end else begin
        want = due_results.pop_front();
        if (out_tdata !== want.captured_char || out_tuser[1:0] !== want.capture_kind ||
            out_tuser[3:2] !== want.status) begin
          miss_count++;
          if (miss_count <= 10)
            $display("mismatch at cycle %0d: expected char %02h kind %0d status %0d, got char %02h kind %0d status %0d",
                     cycle_count, want.captured_char, want.capture_kind, want.status,
                     out_tdata, out_tuser[1:0], out_tuser[3:2]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("smtp_command_argument_parser_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int         target;
    int         next_hold;
    int         loc;
    int         dom;
    bit         lit;
    logic [1:0] op;
    result_t    fixed_res;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_rows[i]) begin
      fixed_res = '{opening_rows[i].x_char, opening_rows[i].x_kind, opening_rows[i].x_stat};
      send_byte(opening_rows[i].op, opening_rows[i].ch, opening_rows[i].start,
                opening_rows[i].fixed, fixed_res);
    end
    wait_all_results();

    // length limits: last byte inside and first byte over, then an empty local part
    hold_req = 1'b1;
    run_line(OP_RCPT, LOCAL_MAX + 1, 3, 1'b0, 1'b0);
    run_line(OP_MAIL, 1, DOMAIN_MAX + 1, 1'b0, 1'b0);
    run_line(OP_RCPT, 2, DOMAIN_MAX - 1, 1'b1, 1'b0);
    run_line(OP_MAIL, 0, 2, 1'b0, 1'b0);
    wait_all_results();

    target = bytes_sent + RANDOM_BYTES;
    next_hold = bytes_sent + 60;
    while (bytes_sent < target) begin
      op  = 2'($urandom_range(0, 2));
      lit = ($urandom_range(0, 3) == 0);
      loc = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
      dom = $urandom_range(lit ? 0 : 1, 10);
      run_line(op, loc, dom, lit, 1'b1);
      if (bytes_sent >= next_hold) begin
        hold_req = 1'b1;
        next_hold = bytes_sent + 60;
        if ($urandom_range(0, 1)) wait_all_results();
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (miss_count == 0 && due_results.size() == 0) begin
      $display("smtp_command_argument_parser_core_tb OK");
    end else begin
      $display("smtp_command_argument_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule
